[hw/rtl/crmm_pkg.sv]
// Shared types and constants for the centered running min/max unit.
package crmm_pkg;

	localparam int MAX_HW_DEF = 32;
	localparam int SMP_W      = 16;
	localparam int HW_W       = 6;

	localparam logic [HW_W-1:0] HW_RESET = 6'd1;

	// identity values for a running max / min
	localparam logic signed [SMP_W-1:0] HI_INIT = 16'sh8000;
	localparam logic signed [SMP_W-1:0] LO_INIT = 16'sh7fff;

	// partial result travelling down the cell row
	typedef struct packed {
		logic                    vld;
		logic                    last;
		logic signed [SMP_W-1:0] hi;
		logic signed [SMP_W-1:0] lo;
	} tok_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN
	} state_t;

endpackage

[hw/rtl/crmm_cell.sv]
// One cell of the sample row: holds one sample and folds it into a passing token.
module crmm_cell #(
	parameter int CW = 7
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    shift_en,
	input  logic signed [crmm_pkg::SMP_W-1:0]       smp_in,
	output logic signed [crmm_pkg::SMP_W-1:0]       smp_out,
	input  logic                                    adv,
	input  crmm_pkg::tok_t                          tok_in,
	input  logic [CW-1:0]                           rem_in,
	output crmm_pkg::tok_t                          tok_out,
	output logic [CW-1:0]                           rem_out
);
	import crmm_pkg::*;

	logic signed [SMP_W-1:0] smp_q;
	logic                    vld_q;
	tok_t                    tok_q;
	logic [CW-1:0]           rem_q;
	tok_t                    tok_d;
	logic [CW-1:0]           rem_d;

	// rem counts samples still to include, starting from this cell
	always_comb begin
		tok_d = tok_in;
		rem_d = rem_in;
		if (rem_in != '0) begin
			if (smp_q > tok_in.hi) tok_d.hi = smp_q;
			if (smp_q < tok_in.lo) tok_d.lo = smp_q;
			rem_d = rem_in - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) smp_q <= smp_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= tok_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tok_q <= tok_d;
			rem_q <= rem_d;
		end
	end

	always_comb begin
		tok_out     = tok_q;
		tok_out.vld = vld_q;
	end

	assign smp_out = smp_q;
	assign rem_out = rem_q;

endmodule

[hw/rtl/crmm_ctrl.sv]
// Sequencer: tracks fill level, issues one token per result, waits for the row to drain.
module crmm_ctrl #(
	parameter int MAX_HALF_WINDOW = crmm_pkg::MAX_HW_DEF,
	parameter int CW              = $clog2(2 * MAX_HALF_WINDOW + 2)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [crmm_pkg::HW_W-1:0]     half_window,
	input  logic                          s_tvalid,
	input  logic                          s_tlast,
	output logic                          s_tready,
	output logic                          shift_en,
	input  logic                          adv,
	input  logic                          done,
	output crmm_pkg::tok_t                inj,
	output logic [CW-1:0]                 inj_rem
);
	import crmm_pkg::*;

	localparam int DEPTH = 2 * MAX_HALF_WINDOW + 1;
	localparam logic [HW_W-1:0] MHW = HW_W'(MAX_HALF_WINDOW);

	state_t          state_q, state_d;
	logic [CW-1:0]   fill_q;
	logic [CW-1:0]   infl_q;
	logic [HW_W-1:0] win_q;
	logic [CW-1:0]   c_q;
	logic            fin_q;
	logic [CW-1:0]   a_q;

	logic [HW_W-1:0] hw_eff;
	logic [CW-1:0]   hw_ext;
	logic [CW-1:0]   hw_l;
	logic [CW-1:0]   first;
	logic [CW-1:0]   oldest;
	logic [CW-1:0]   reach;
	logic            take;
	logic            issue;

	assign hw_eff = (half_window > MHW) ? MHW : half_window;
	assign hw_ext = CW'(hw_eff);
	assign hw_l   = CW'(win_q);
	assign first  = (fill_q < hw_ext) ? fill_q : hw_ext;
	assign take   = (state_q == ST_IDLE) && s_tvalid;
	assign issue  = (state_q == ST_ISSUE) && adv;

	// window end for the current position, clipped at the sequence start and store depth
	always_comb begin
		reach  = a_q + hw_l;
		oldest = (reach < c_q) ? reach : c_q;
		if (oldest > CW'(DEPTH - 1)) oldest = CW'(DEPTH - 1);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid && (s_tlast || fill_q >= hw_ext)) state_d = ST_ISSUE;
			end
			ST_ISSUE: begin
				if (adv && (!fin_q || a_q == '0)) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (infl_q == '0) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		shift_en = 1'b0;
		inj.vld  = 1'b0;
		inj.last = fin_q && (a_q == '0);
		inj.hi   = HI_INIT;
		inj.lo   = LO_INIT;
		inj_rem  = oldest + CW'(1);
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				shift_en = s_tvalid;
			end
			ST_ISSUE: inj.vld = 1'b1;
			ST_DRAIN: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			infl_q  <= '0;
		end else begin
			state_q <= state_d;
			infl_q  <= infl_q + CW'(issue) - CW'(done);
			if (take) begin
				if (s_tlast) fill_q <= '0;
				else if (fill_q != CW'(DEPTH)) fill_q <= fill_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			win_q <= hw_eff;
			c_q   <= fill_q;
			fin_q <= s_tlast;
			a_q   <= s_tlast ? first : hw_ext;
		end else if (issue && a_q != '0) begin
			a_q <= a_q - CW'(1);
		end
	end

endmodule

[hw/rtl/centered_running_min_max_unit.sv]
// Top level of the centered running min/max unit: config register, cell row, output register.
//
//  channel  | signals                                   | word
//  ---------+-------------------------------------------+----------------------------
//  cfg      | cfg_valid, cfg_ready, cfg_data[5:0]       | half_window
//  s (in)   | s_tvalid, s_tready, s_tdata, s_tlast      | sample; tlast = is_final
//  m (out)  | m_tvalid, m_tready, m_tdata, m_tlast      | upper, lower; tlast = end_of_run
//
// One input word per pass: the word is accepted, then one token per result is issued per
// cycle while the output is not stalled, into a row of 2*MAX_HALF_WINDOW+1 cells, each
// token folding at most one sample per cell; the next word waits until the row has drained.
// A word with no result is only shifted into the row.
// Reset clears the fill count, sequencer and valid bits, and sets half_window to 1.
// m_tready low with a result held freezes the row; a new word is taken while it waits.
module centered_running_min_max_unit #(
	parameter int MAX_HALF_WINDOW = crmm_pkg::MAX_HW_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [crmm_pkg::HW_W-1:0]     cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [15:0]                   s_tdata,   // [15:0] sample
	input  logic                          s_tlast,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [31:0]                   m_tdata,   // [15:0] upper, [31:16] lower
	output logic                          m_tlast
);
	import crmm_pkg::*;

	localparam int DEPTH = 2 * MAX_HALF_WINDOW + 1;
	localparam int CW    = $clog2(DEPTH + 1);

	logic [HW_W-1:0]         hw_q;
	logic                    shift_en;
	logic                    adv;
	logic                    done;
	logic                    m_vld_q;
	tok_t                    out_q;
	tok_t                    inj;
	logic [CW-1:0]           inj_rem;

	logic signed [SMP_W-1:0] smp_chain [DEPTH];
	tok_t                    tok_chain [DEPTH+1];
	logic [CW-1:0]           rem_chain [DEPTH];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q <= HW_RESET;
		end else if (cfg_valid) begin
			hw_q <= cfg_data;
		end
	end

	assign adv  = !m_vld_q || m_tready;
	assign done = adv && tok_chain[DEPTH].vld;

	crmm_ctrl #(
		.MAX_HALF_WINDOW(MAX_HALF_WINDOW),
		.CW             (CW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.half_window(hw_q),
		.s_tvalid   (s_tvalid),
		.s_tlast    (s_tlast),
		.s_tready   (s_tready),
		.shift_en   (shift_en),
		.adv        (adv),
		.done       (done),
		.inj        (inj),
		.inj_rem    (inj_rem)
	);

	assign smp_chain[0] = s_tdata;
	assign tok_chain[0] = inj;
	assign rem_chain[0] = inj_rem;

	// cell k holds the sample that arrived k words ago
	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		if (k < DEPTH - 1) begin : g_mid
			crmm_cell #(.CW(CW)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.shift_en(shift_en),
				.smp_in  (smp_chain[k]),
				.smp_out (smp_chain[k+1]),
				.adv     (adv),
				.tok_in  (tok_chain[k]),
				.rem_in  (rem_chain[k]),
				.tok_out (tok_chain[k+1]),
				.rem_out (rem_chain[k+1])
			);
		end else begin : g_end
			crmm_cell #(.CW(CW)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.shift_en(shift_en),
				.smp_in  (smp_chain[k]),
				.smp_out (),
				.adv     (adv),
				.tok_in  (tok_chain[k]),
				.rem_in  (rem_chain[k]),
				.tok_out (tok_chain[k+1]),
				.rem_out ()
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_vld_q <= 1'b0;
		end else if (adv) begin
			m_vld_q <= tok_chain[DEPTH].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) out_q <= tok_chain[DEPTH];
	end

	assign m_tvalid = m_vld_q;
	assign m_tdata  = {out_q.lo, out_q.hi};
	assign m_tlast  = out_q.last;

endmodule
